@@ sv/odq_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list deque package
// Sizes, action and status codes, and the beat types of both channels.
// ----------------------------------------------------------------------------
package odq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LIST_HEAD = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_LIST_TAIL = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_POS  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]          action;
        logic signed [DATA_WIDTH-1:0] item_value;
        logic [POS_W-1:0]             position;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] elem_value;
        logic [STATUS_W-1:0]          status;
        logic                         last;
        logic [COUNT_W-1:0]           elem_count;
    } out_beat_t;

endpackage

@@ sv/ordered_list_deque_engine_top.sv @@
// ----------------------------------------------------------------------------
// Ordered list deque engine
// Bounded list of signed values kept in a circular buffer in one RAM, with
// push at either end, removal at a position, clear and full listing.
// ----------------------------------------------------------------------------
// Push, clear and rejected actions pass through the acknowledge state and give
// their single beat from the output register. A removal shifts each entry
// behind the gap one place toward the head. A listing fetches its first entry
// on acceptance and then gives one beat per cycle while the result side takes them.
// A new item is accepted only once the last one is done; a listing or removal
// is bounded by the one-read, one-write RAM port.
// Reset clears count, head, cursor and handshake state; the entry RAM is not
// cleared, since an entry is only read after it has been written.
module ordered_list_deque_engine_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  odq_pkg::in_beat_t  s_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output odq_pkg::out_beat_t m_beat
);
    import odq_pkg::*;

    // The controller is idle, shifting entries toward the head after a
    // removal, streaming a listing, or holding a single acknowledgement.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_LIST  = 4'b0100,
        ST_ACK   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    walk_reg, walk_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                from_tail_reg, from_tail_next;
    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_beat_reg, m_beat_next;

    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_wdata, ram_rdata;

    logic              accept;
    logic              out_free;
    logic              list_last;
    logic [CNT_W-1:0]  walk_plus1;

    // Physical slot of a logical position, counted from 0 at the head.
    // The sum stays below twice the depth, so one subtract wraps it.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  logical);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(logical);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    // Logical position of the walk step when listing in either direction.
    function automatic logic [CNT_W-1:0] list_pos(input logic             tail,
                                                  input logic [CNT_W-1:0] fill,
                                                  input logic [CNT_W-1:0] step);
        return tail ? CNT_W'(fill - CNT_W'(1) - step) : step;
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign walk_plus1 = walk_reg + CNT_W'(1);
    assign list_last  = (walk_plus1 == fill_reg);

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    odq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        walk_next      = walk_reg;
        status_next    = status_reg;
        from_tail_next = from_tail_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_beat_next    = m_beat_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_of(head_reg, walk_reg);
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = slot_of(head_reg, walk_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next = STAT_DONE;
                    state_next  = ST_ACK;
                    case (s_beat.action)
                        ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
                            if (fill_reg >= CNT_W'(DEPTH)) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = s_beat.item_value;
                                fill_next = fill_reg + CNT_W'(1);
                                if (s_beat.action == ACT_PUSH_HEAD) begin
                                    head_next = (head_reg == '0) ? ADDR_W'(DEPTH - 1)
                                                                 : head_reg - ADDR_W'(1);
                                    ram_waddr = head_next;
                                end else begin
                                    ram_waddr = slot_of(head_reg, fill_reg);
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (s_beat.position == '0 || s_beat.position > fill_reg) begin
                                status_next = STAT_BAD_POS;
                            end else if (s_beat.position == fill_reg) begin
                                // Removing the tail entry moves nothing.
                                fill_next = fill_reg - CNT_W'(1);
                            end else begin
                                // Fetch the entry behind the gap; it lands next cycle.
                                walk_next  = CNT_W'(s_beat.position - POS_W'(1));
                                ram_re     = 1'b1;
                                ram_raddr  = slot_of(head_reg, CNT_W'(s_beat.position));
                                state_next = ST_SHIFT;
                            end
                        end
                        ACT_CLEAR: begin
                            fill_next = '0;
                            head_next = '0;
                        end
                        ACT_LIST_HEAD, ACT_LIST_TAIL: begin
                            if (fill_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                from_tail_next = (s_beat.action == ACT_LIST_TAIL);
                                walk_next      = '0;
                                ram_re         = 1'b1;
                                ram_raddr      = slot_of(head_reg,
                                                         list_pos(from_tail_next, fill_reg,
                                                                  CNT_W'(0)));
                                state_next     = ST_LIST;
                            end
                        end
                        default: begin
                            // Undefined actions are dropped without a beat.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SHIFT: begin
                // Write the fetched entry one place toward the head and fetch
                // the one two places on; the two slots never coincide.
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_reg, walk_reg);
                ram_wdata = ram_rdata;
                if ((walk_reg + CNT_W'(2)) < fill_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(head_reg, walk_reg + CNT_W'(2));
                    walk_next = walk_plus1;
                end else begin
                    fill_next   = fill_reg - CNT_W'(1);
                    walk_next   = '0;
                    status_next = STAT_DONE;
                    state_next  = ST_ACK;
                end
            end

            ST_LIST: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_beat_next.elem_value = ram_rdata;
                    m_beat_next.status     = STAT_DONE;
                    m_beat_next.last       = list_last;
                    m_beat_next.elem_count = COUNT_W'(fill_reg);
                    if (list_last) begin
                        walk_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        walk_next = walk_plus1;
                        ram_re    = 1'b1;
                        ram_raddr = slot_of(head_reg,
                                            list_pos(from_tail_reg, fill_reg, walk_plus1));
                    end
                end
            end

            ST_ACK: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_beat_next.elem_value = '0;
                    m_beat_next.status     = status_reg;
                    m_beat_next.last       = 1'b1;
                    m_beat_next.elem_count = COUNT_W'(fill_reg);
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            head_reg    <= '0;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        from_tail_reg <= from_tail_next;
        m_beat_reg    <= m_beat_next;
    end

    // The list never holds more entries than the buffer has slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Every item leaves the walk cursor back at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (walk_reg == '0))
        else $error("walk cursor not cleared at idle");

    // A shift never reads the slot it is writing in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write collide on one slot");

    // Any beat with a non-done status is the single, final beat of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_reg.status != STAT_DONE) |-> m_beat_reg.last)
        else $error("error status on a non-final beat");

    // A listing only runs over a non-empty list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> (walk_reg < fill_reg))
        else $error("listing cursor beyond fill count");

endmodule

@@ sv/odq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
module odq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
